>>> src/epd_pkg.sv
// Shared types and field widths for the expiring peer directory.
package epd_pkg;

    localparam int KEY_W = 64;
    localparam int ID_W  = 16;
    localparam int TM_W  = 32;
    localparam int MP_W  = 4;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic CFG_MAX_PEERS    = 1'b0;
    localparam logic CFG_SWEEP_PERIOD = 1'b1;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_SW_KEY  = 14'b00000000000010,
        ST_SW_CNT  = 14'b00000000000100,
        ST_SW_WAIT = 14'b00000000001000,
        ST_SW_SLT  = 14'b00000000010000,
        ST_SW_END  = 14'b00000000100000,
        ST_FD_KEY  = 14'b00000001000000,
        ST_FD_CMP  = 14'b00000010000000,
        ST_Q_WAIT  = 14'b00000100000000,
        ST_Q_OUT   = 14'b00001000000000,
        ST_UL_WAIT = 14'b00010000000000,
        ST_UL_RD   = 14'b00100000000000,
        ST_UP_WR   = 14'b01000000000000,
        ST_RESP    = 14'b10000000000000
    } state_t;

endpackage

>>> src/epd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module epd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/expiring_peer_directory.sv
// Top level of the expiring peer directory: sequencer, key scan and list rewrite.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata key,peer,expiry,now; tuser cmd
//  m_      | out | m_tvalid/m_tready  | tdata peer,expiry; tuser valid,status; tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The key scan visits each key slot and reads the key of each used one. A matched
// list is swept first, dropping expired peers from its tail; then, on an update,
// each kept peer is read and the new list is written back. A due full sweep
// first visits every key slot and sweeps the list of each used key.
// s_tready is high only when the sequencer is idle; an item is taken while the
// last result still waits on m_. Reset clears key use bits and control state;
// no clearing pass is needed.
module expiring_peer_directory
    import epd_pkg::*;
#(
    parameter int KEY_SLOTS  = 64,
    parameter int PEER_SLOTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // block_key[63:0], peer_id[79:64], expiry_time[111:80], now[143:112]
    input  logic [0:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // out_peer_id[15:0], out_expiry[47:16]
    output logic [1:0]   m_tuser,   // peer_valid[0], status[1]
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int KW  = KEY_SLOTS > 1 ? $clog2(KEY_SLOTS) : 1;
    localparam int PW  = PEER_SLOTS > 1 ? $clog2(PEER_SLOTS) : 1;
    localparam int CW  = $clog2(PEER_SLOTS + 1);
    localparam int PD  = KEY_SLOTS * PEER_SLOTS;
    localparam int PAW = PD > 1 ? $clog2(PD) : 1;
    localparam int EW  = ID_W + TM_W;

    state_t state_reg;

    logic [MP_W-1:0] max_peers_reg;
    logic [TM_W-1:0] period_reg;
    logic [TM_W-1:0] last_sweep_reg;
    logic [KEY_SLOTS-1:0] used_reg;

    logic            cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [ID_W-1:0] pid_reg;
    logic [TM_W-1:0] exp_reg;
    logic [TM_W-1:0] now_reg;
    logic            full_reg;

    logic [KW:0]     k_reg;
    logic [KW-1:0]   free_reg;
    logic            free_ok_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   m_reg;
    logic [CW-1:0]   r_reg;
    logic            rem_reg;
    logic            ins_reg;
    logic [EW-1:0]   buf_reg [PEER_SLOTS];
    logic            status_reg;

    logic            m_tvalid_reg;
    logic [47:0]     m_tdata_reg;
    logic [1:0]      m_tuser_reg;
    logic            m_tlast_reg;

    // RAM ports
    logic              key_we;
    logic [KEY_W-1:0]  key_rdata;
    logic              cnt_we;
    logic [CW-1:0]     cnt_wdata;
    logic [CW-1:0]     cnt_rdata;
    logic              pr_we;
    logic [PAW-1:0]    pr_waddr;
    logic [PAW-1:0]    pr_raddr;
    logic [EW-1:0]     pr_wdata;
    logic [EW-1:0]     pr_rdata;

    logic [KW-1:0]   k_idx;
    logic            out_free;
    logic            out_load;
    logic            sweep_due;
    logic [CW-1:0]   lim;
    logic [CW:0]     total;
    logic [CW-1:0]   cnt_clamped;
    logic            take_new;
    logic [EW-1:0]   buf_head;
    logic [TM_W-1:0] pr_exp;
    logic [ID_W-1:0] pr_id;

    assign k_idx    = k_reg[KW-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ((state_reg == ST_Q_OUT) || (state_reg == ST_RESP)) && out_free;
    assign sweep_due = {1'b0, s_tdata[143:112]} >=
                       ({1'b0, last_sweep_reg} + {1'b0, period_reg});
    assign pr_exp   = pr_rdata[TM_W-1:0];
    assign pr_id    = pr_rdata[EW-1:TM_W];

    always_comb begin
        if (max_peers_reg == '0) begin
            lim = CW'(1);
        end else if ({28'd0, max_peers_reg} > 32'(PEER_SLOTS)) begin
            lim = CW'(PEER_SLOTS);
        end else begin
            lim = CW'(max_peers_reg);
        end
    end

    assign total       = ({1'b0, m_reg} + (CW+1)'(1) > {1'b0, lim}) ? {1'b0, lim}
                                                                   : {1'b0, m_reg} + (CW+1)'(1);
    assign cnt_clamped = (cnt_rdata > CW'(PEER_SLOTS)) ? CW'(PEER_SLOTS) : cnt_rdata;
    assign buf_head    = buf_reg[r_reg[PW-1:0]];
    assign take_new    = !ins_reg && ((r_reg >= m_reg) || (buf_head[TM_W-1:0] <= exp_reg));

    assign pr_raddr = PAW'(k_idx) * PAW'(PEER_SLOTS) + PAW'(idx_reg);
    assign pr_waddr = PAW'(k_idx) * PAW'(PEER_SLOTS) + PAW'(idx_reg);
    assign pr_we    = (state_reg == ST_UP_WR);
    assign pr_wdata = take_new ? {pid_reg, exp_reg} : buf_head;

    assign key_we    = (state_reg == ST_FD_KEY) && (k_reg == (KW+1)'(KEY_SLOTS))
                       && (cmd_reg == CMD_UPDATE) && free_ok_reg;
    assign cnt_we    = (state_reg == ST_SW_END)
                       || ((state_reg == ST_UP_WR) && ({1'b0, idx_reg} + (CW+1)'(1) == total));
    assign cnt_wdata = (state_reg == ST_UP_WR) ? total[CW-1:0] : n_reg;

    epd_ram #(.WIDTH(KEY_W), .DEPTH(KEY_SLOTS)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(free_reg), .wdata(key_reg),
        .raddr(k_idx), .rdata(key_rdata)
    );

    epd_ram #(.WIDTH(CW), .DEPTH(KEY_SLOTS)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(k_idx), .wdata(cnt_wdata),
        .raddr(k_idx), .rdata(cnt_rdata)
    );

    epd_ram #(.WIDTH(EW), .DEPTH(PD)) u_peer_ram (
        .aclk(aclk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
        .raddr(pr_raddr), .rdata(pr_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_peers_reg  <= MP_W'(8);
            period_reg     <= TM_W'(1000);
            last_sweep_reg <= '0;
            used_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MAX_PEERS:    max_peers_reg <= cfg_data[MP_W-1:0];
                    CFG_SWEEP_PERIOD: period_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg     <= s_tuser[0];
                        key_reg     <= s_tdata[63:0];
                        pid_reg     <= s_tdata[79:64];
                        exp_reg     <= s_tdata[111:80];
                        now_reg     <= s_tdata[143:112];
                        full_reg    <= sweep_due;
                        k_reg       <= '0;
                        free_ok_reg <= 1'b0;
                        state_reg   <= sweep_due ? ST_SW_KEY : ST_FD_KEY;
                    end
                end
                ST_SW_KEY: begin
                    if (k_reg == (KW+1)'(KEY_SLOTS)) begin
                        last_sweep_reg <= now_reg;
                        full_reg       <= 1'b0;
                        k_reg          <= '0;
                        state_reg      <= ST_FD_KEY;
                    end else if (used_reg[k_idx]) begin
                        state_reg <= ST_SW_CNT;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_SW_CNT: begin
                    n_reg <= cnt_clamped;
                    if (cnt_clamped == '0) begin
                        state_reg <= ST_SW_END;
                    end else begin
                        idx_reg   <= cnt_clamped - 1'b1;
                        state_reg <= ST_SW_WAIT;
                    end
                end
                ST_SW_WAIT: state_reg <= ST_SW_SLT;
                ST_SW_SLT: begin
                    if (pr_exp < now_reg) begin
                        n_reg <= n_reg - 1'b1;
                        if (n_reg == CW'(1)) begin
                            state_reg <= ST_SW_END;
                        end else begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= ST_SW_WAIT;
                        end
                    end else begin
                        state_reg <= ST_SW_END;
                    end
                end
                ST_SW_END: begin
                    idx_reg <= '0;
                    if (full_reg) begin
                        used_reg[k_idx] <= (n_reg != '0);
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SW_KEY;
                    end else if (cmd_reg == CMD_QUERY) begin
                        if (n_reg == '0) begin
                            status_reg <= 1'b0;
                            state_reg  <= ST_RESP;
                        end else begin
                            state_reg <= ST_Q_WAIT;
                        end
                    end else begin
                        m_reg   <= '0;
                        rem_reg <= 1'b0;
                        r_reg   <= '0;
                        ins_reg <= 1'b0;
                        state_reg <= (n_reg == '0) ? ST_UP_WR : ST_UL_WAIT;
                    end
                end
                ST_FD_KEY: begin
                    if (k_reg == (KW+1)'(KEY_SLOTS)) begin
                        if (cmd_reg == CMD_UPDATE && free_ok_reg) begin
                            k_reg           <= {1'b0, free_reg};
                            used_reg[free_reg] <= 1'b1;
                            idx_reg <= '0;
                            m_reg   <= '0;
                            r_reg   <= '0;
                            ins_reg <= 1'b0;
                            state_reg <= ST_UP_WR;
                        end else begin
                            // absent key on query, or no free slot on update
                            status_reg <= (cmd_reg == CMD_UPDATE);
                            state_reg  <= ST_RESP;
                        end
                    end else if (used_reg[k_idx]) begin
                        state_reg <= ST_FD_CMP;
                    end else begin
                        if (!free_ok_reg) begin
                            free_ok_reg <= 1'b1;
                            free_reg    <= k_idx;
                        end
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_FD_CMP: begin
                    if (key_rdata == key_reg) begin
                        state_reg <= ST_SW_CNT;   // count read for k is already out
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_FD_KEY;
                    end
                end
                ST_Q_WAIT: state_reg <= ST_Q_OUT;
                ST_Q_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {pr_exp, pr_id};
                        m_tuser_reg  <= 2'b01;
                        m_tlast_reg  <= (idx_reg + 1'b1 == n_reg);
                        if (idx_reg + 1'b1 == n_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_Q_WAIT;
                        end
                    end
                end
                ST_UL_WAIT: state_reg <= ST_UL_RD;
                ST_UL_RD: begin
                    if (!rem_reg && pr_id == pid_reg) begin
                        rem_reg <= 1'b1;
                    end else begin
                        buf_reg[m_reg[PW-1:0]] <= pr_rdata;
                        m_reg <= m_reg + 1'b1;
                    end
                    if (idx_reg + 1'b1 == n_reg) begin
                        idx_reg   <= '0;
                        state_reg <= ST_UP_WR;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_UL_WAIT;
                    end
                end
                ST_UP_WR: begin
                    if (take_new) begin
                        ins_reg <= 1'b1;
                    end else begin
                        r_reg <= r_reg + 1'b1;
                    end
                    if ({1'b0, idx_reg} + (CW+1)'(1) == total) begin
                        status_reg <= 1'b0;
                        state_reg  <= ST_RESP;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_tdata_reg  <= '0;
                        m_tuser_reg  <= {status_reg, 1'b0};
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> tb/sv/tb_expiring_peer_directory.sv
// Self-checking testbench for the expiring peer directory.
module tb_expiring_peer_directory
    import epd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS   = 64;
    localparam int NPEERS  = 8;
    localparam int SETTLE  = 1200;   // cycles waited after the last expected result is taken

    typedef struct packed {
        logic            pv;
        logic [ID_W-1:0] pid;
        logic [TM_W-1:0] exp;
        logic            last;
        logic            status;
    } peer_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;  // block_key, peer_id, expiry_time, now
    logic [0:0]   s_tuser = '0;  // cmd
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;       // out_peer_id, out_expiry
    logic [1:0]   m_tuser;       // peer_valid, status
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    expiring_peer_directory u_dut (.*);

    always #10 aclk = ~aclk;

    // directory mirror
    logic [KEY_W-1:0] dir_key  [NKEYS];
    logic             dir_used [NKEYS];
    int unsigned      dir_cnt  [NKEYS];
    logic [ID_W-1:0]  dir_pid  [NKEYS][NPEERS];
    logic [TM_W-1:0]  dir_exp  [NKEYS][NPEERS];
    logic [TM_W-1:0]  last_sweep;
    logic [MP_W-1:0]  max_peers_reg;
    logic [TM_W-1:0]  sweep_period_reg;

    peer_res_t   pending_q[$];
    int unsigned n_errors = 0;
    int unsigned rx_hold = 0;
    int unsigned burst_left = 0;
    logic [TM_W-1:0] cur_now = '0;
    logic [KEY_W-1:0] key_pool[12];

    function automatic void trim_expired(int k, logic [TM_W-1:0] now);
        int unsigned n;
        n = dir_cnt[k];
        while (n > 0 && dir_exp[k][n-1] < now) n--;
        dir_cnt[k] = n;
    endfunction

    function automatic void predict_item(logic cmd, logic [KEY_W-1:0] key,
                                         logic [ID_W-1:0] pid, logic [TM_W-1:0] ex,
                                         logic [TM_W-1:0] now);
        int k;
        int unsigned n, m, pos, lim;
        logic [ID_W-1:0] tid[NPEERS+1];
        logic [TM_W-1:0] tex[NPEERS+1];
        bit removed;
        peer_res_t r;
        k = -1;
        removed = 0;
        m = 0;
        if ({1'b0, now} >= {1'b0, last_sweep} + {1'b0, sweep_period_reg}) begin
            for (int i = 0; i < NKEYS; i++) begin
                if (dir_used[i]) begin
                    trim_expired(i, now);
                    if (dir_cnt[i] == 0) dir_used[i] = 0;
                end
            end
            last_sweep = now;
        end
        for (int i = 0; i < NKEYS; i++)
            if (k < 0 && dir_used[i] && dir_key[i] == key) k = i;
        r = '{pv: 1'b0, pid: '0, exp: '0, last: 1'b1, status: 1'b0};
        if (cmd == CMD_QUERY) begin
            if (k >= 0) begin
                trim_expired(k, now);
                n = dir_cnt[k];
                for (int unsigned i = 0; i < n; i++)
                    pending_q.push_back('{1'b1, dir_pid[k][i], dir_exp[k][i], i + 1 == n, 1'b0});
                if (n > 0) return;
            end
            pending_q.push_back(r);
            return;
        end
        if (k < 0) begin
            for (int i = 0; i < NKEYS; i++)
                if (k < 0 && !dir_used[i]) k = i;
            if (k < 0) begin
                r.status = 1'b1;
                pending_q.push_back(r);
                return;
            end
            dir_used[k] = 1;
            dir_key[k]  = key;
            dir_cnt[k]  = 0;
        end
        trim_expired(k, now);
        n = dir_cnt[k];
        for (int unsigned i = 0; i < n; i++) begin
            if (!removed && dir_pid[k][i] == pid) begin
                removed = 1;
            end else begin
                tid[m] = dir_pid[k][i];
                tex[m] = dir_exp[k][i];
                m++;
            end
        end
        pos = 0;
        while (pos < m && tex[pos] > ex) pos++;
        for (int unsigned i = m; i > pos; i--) begin
            tid[i] = tid[i-1];
            tex[i] = tex[i-1];
        end
        tid[pos] = pid;
        tex[pos] = ex;
        m++;
        lim = max_peers_reg;
        if (lim < 1) lim = 1;
        if (lim > NPEERS) lim = NPEERS;
        if (m > lim) m = lim;
        for (int unsigned i = 0; i < m; i++) begin
            dir_pid[k][i] = tid[i];
            dir_exp[k][i] = tex[i];
        end
        dir_cnt[k] = m;
        pending_q.push_back(r);
    endfunction

    // result checker
    always @(posedge aclk) begin
        peer_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tdata[15:0], m_tdata[47:16], m_tlast, m_tuser[1]};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
                n_errors++;
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $realtime, want, got);
                    n_errors++;
                end
            end
        end
    end

    // receiver stalls: three modes in turn (always ready, random, periodic gaps); long hold-off on request
    always @(posedge aclk) begin
        int unsigned cyc;
        if (!aresetn) begin
            m_tready <= 1'b0;
            cyc = 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            cyc++;
            case ((cyc / 64) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) < 65);
                default: m_tready <= (cyc % 5) != 0;
            endcase
        end
    end

    task automatic send_item(logic cmd, logic [KEY_W-1:0] key, logic [ID_W-1:0] pid,
                             logic [TM_W-1:0] ex, logic [TM_W-1:0] now);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {now, ex, pid, key};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        predict_item(cmd, key, pid, ex, now);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_PEERS) max_peers_reg = val[MP_W-1:0];
        else sweep_period_reg = val;
        @(posedge aclk);
    endtask

    function automatic logic [TM_W-1:0] tick(int unsigned step);
        logic [TM_W:0] t;
        t = {1'b0, cur_now} + step;
        cur_now = t[TM_W] ? '1 : t[TM_W-1:0];
        return cur_now;
    endfunction

    function automatic logic [TM_W-1:0] expiry_near(int lo, int hi);
        longint t;
        t = longint'(cur_now) + longint'(lo) + longint'($urandom_range(0, hi - lo));
        if (t < 0) t = 0;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        return t[TM_W-1:0];
    endfunction

    task automatic test_directed();
        logic [KEY_W-1:0] ka, kb;
        ka = '0;
        kb = '1;
        send_item(CMD_QUERY, ka, '0, '0, tick(0));          // absent key
        send_item(CMD_UPDATE, ka, 16'h0001, 32'd500, tick(1));
        send_item(CMD_UPDATE, ka, 16'hFFFF, '1, tick(1));
        send_item(CMD_UPDATE, ka, 16'h0000, 32'd500, tick(1)); // equal expiry goes ahead
        send_item(CMD_UPDATE, ka, 16'h0002, 32'd0, tick(1));   // already expired, still kept
        send_item(CMD_QUERY, ka, '0, '0, cur_now - 1);
        send_item(CMD_UPDATE, ka, 16'h0001, 32'd900, tick(1)); // moves existing peer
        send_item(CMD_QUERY, ka, '0, '0, tick(0));              // drops the expired entry
        send_item(CMD_UPDATE, kb, 16'hA5A5, 32'd50, tick(1));
        send_item(CMD_UPDATE, kb, 16'h5A5A, 32'd60, tick(1));
        send_item(CMD_QUERY, kb, '0, '0, tick(55));             // both peers expired
        send_item(CMD_QUERY, kb, '0, '0, tick(10));             // list empty, key kept
        write_reg(CFG_MAX_PEERS, 32'd2);
        send_item(CMD_QUERY, ka, '0, '0, tick(1));              // not cut until update
        send_item(CMD_UPDATE, ka, 16'h0003, 32'd700, tick(1));
        send_item(CMD_QUERY, ka, '0, '0, tick(1));
        write_reg(CFG_MAX_PEERS, 32'd0);                        // saturates to one
        send_item(CMD_UPDATE, ka, 16'h0004, 32'd800, tick(1));
        send_item(CMD_QUERY, ka, '0, '0, tick(1));
        write_reg(CFG_MAX_PEERS, 32'hF);                        // saturates to eight
        for (int i = 0; i < 4; i++)
            send_item(CMD_UPDATE, ka, 16'(16'h0010 + i), expiry_near(100, 900), tick(1));
        send_item(CMD_QUERY, ka, '0, '0, tick(1));
        send_item(CMD_QUERY, kb, '0, '0, tick(1000));           // full sweep due
    endtask

    // fill every key slot, then further new keys are refused
    task automatic test_table_full();
        write_reg(CFG_SWEEP_PERIOD, 32'hFFFF_FFFF);
        for (int i = 0; i < NKEYS + 3; i++)
            send_item(CMD_UPDATE, {$urandom, $urandom}, 16'($urandom),
                      expiry_near(4000, 5000), tick(1));
        send_item(CMD_QUERY, {$urandom, $urandom}, '0, '0, tick(1));
        write_reg(CFG_SWEEP_PERIOD, 32'd0);
        send_item(CMD_QUERY, key_pool[0], '0, '0, tick(6000));  // sweep clears all
    endtask

    task automatic test_backpressure();
        for (int i = 0; i < 8; i++)
            send_item(CMD_UPDATE, key_pool[1], 16'(i), expiry_near(500, 900), tick(1));
        drain();
        rx_hold = 600;
        for (int i = 0; i < 6; i++)
            send_item(CMD_QUERY, key_pool[1], '0, '0, tick(1));
        drain();
    endtask

    task automatic random_phase(int unsigned n);
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0] pid;
        logic [TM_W-1:0] ex;
        for (int unsigned i = 0; i < n; i++) begin
            key = $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(0, 11)];
            pid = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 9));
            ex  = $urandom_range(0, 9) == 0 ? $urandom : expiry_near(-50, 400);
            send_item($urandom_range(0, 9) < 6 ? CMD_UPDATE : CMD_QUERY, key, pid, ex,
                      tick($urandom_range(0, 30)));
        end
    endtask

    task automatic test_random();
        random_phase(10);
        write_reg(CFG_MAX_PEERS, 32'd3);
        write_reg(CFG_SWEEP_PERIOD, 32'd50);
        random_phase(10);
        write_reg(CFG_MAX_PEERS, 32'd8);
        write_reg(CFG_SWEEP_PERIOD, 32'd1000);
        random_phase(10);
        write_reg(CFG_MAX_PEERS, 32'd1);
        write_reg(CFG_SWEEP_PERIOD, 32'hDEAD_BEEF);
        random_phase(5);
    endtask

    // times near the top of the range
    task automatic test_high_time();
        write_reg(CFG_MAX_PEERS, 32'd8);
        write_reg(CFG_SWEEP_PERIOD, 32'd0);
        cur_now = 32'hFFFF_FF00;
        random_phase(12);
        send_item(CMD_UPDATE, key_pool[2], 16'hFFFF, '1, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, key_pool[2], '0, '0, 32'hFFFF_FFFF);
    endtask

    initial begin
        for (int i = 0; i < NKEYS; i++) begin
            dir_used[i] = 0;
            dir_cnt[i]  = 0;
        end
        last_sweep = '0;
        max_peers_reg = 4'd8;
        sweep_period_reg = 32'd1000;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        test_high_time();
        drain();
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #25ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
